[src/grbd_pkg.sv]
// ----------------------------------------------------------------------------
// grbd_pkg: graphics ROM bit descrambler package
// Field widths, row-select bit positions, commands and permutation tables.
// ----------------------------------------------------------------------------
package grbd_pkg;

  localparam int ADDR_W = 21;
  localparam int DATA_W = 16;
  localparam int BG_W   = 8;
  localparam int ROW_W  = 3;
  localparam int ROWS   = 8;

  // address bits that pick the permutation row, LSB first
  localparam int BG_ROW_B0  = 2;
  localparam int BG_ROW_B1  = 11;
  localparam int BG_ROW_B2  = 18;
  localparam int SPR_ROW_B0 = 4;
  localparam int SPR_ROW_B1 = 17;
  localparam int SPR_ROW_B2 = 20;

  typedef enum logic {
    CMD_BG  = 1'b0,
    CMD_SPR = 1'b1
  } cmd_t;

  // result bit (BG_W-1-i) takes source bit BG_PERM[row][i]
  localparam logic [2:0] BG_PERM [ROWS][BG_W] = '{
    '{3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd4, 3'd6},
    '{3'd1, 3'd2, 3'd6, 3'd5, 3'd4, 3'd0, 3'd3, 3'd7},
    '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd7, 3'd6, 3'd5, 3'd0, 3'd1, 3'd4, 3'd3, 3'd2},
    '{3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, 3'd7, 3'd6},
    '{3'd5, 3'd3, 3'd7, 3'd0, 3'd4, 3'd6, 3'd2, 3'd1},
    '{3'd2, 3'd7, 3'd0, 3'd6, 3'd5, 3'd3, 3'd1, 3'd4},
    '{3'd3, 3'd4, 3'd7, 3'd6, 3'd2, 3'd0, 3'd5, 3'd1}
  };

  // result bit (DATA_W-1-i) takes source bit SPR_PERM[row][i]
  localparam logic [3:0] SPR_PERM [ROWS][DATA_W] = '{
    '{4'd9,  4'd3,  4'd4,  4'd5,  4'd7,  4'd1,  4'd11, 4'd8,
      4'd0,  4'd13, 4'd2,  4'd12, 4'd14, 4'd6,  4'd15, 4'd10},
    '{4'd1,  4'd3,  4'd12, 4'd4,  4'd0,  4'd15, 4'd11, 4'd10,
      4'd8,  4'd5,  4'd14, 4'd6,  4'd13, 4'd2,  4'd7,  4'd9},
    '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9,  4'd8,
      4'd7,  4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1,  4'd0},
    '{4'd15, 4'd14, 4'd12, 4'd6,  4'd10, 4'd11, 4'd7,  4'd8,
      4'd9,  4'd2,  4'd3,  4'd4,  4'd5,  4'd13, 4'd1,  4'd0},
    '{4'd1,  4'd6,  4'd2,  4'd5,  4'd15, 4'd7,  4'd11, 4'd9,
      4'd10, 4'd3,  4'd13, 4'd14, 4'd12, 4'd4,  4'd0,  4'd8},
    '{4'd7,  4'd5,  4'd13, 4'd14, 4'd11, 4'd10, 4'd0,  4'd1,
      4'd9,  4'd6,  4'd12, 4'd2,  4'd3,  4'd4,  4'd8,  4'd15},
    '{4'd0,  4'd5,  4'd6,  4'd3,  4'd9,  4'd11, 4'd10, 4'd7,
      4'd1,  4'd13, 4'd2,  4'd14, 4'd4,  4'd12, 4'd8,  4'd15},
    '{4'd9,  4'd12, 4'd4,  4'd2,  4'd15, 4'd0,  4'd11, 4'd8,
      4'd10, 4'd13, 4'd3,  4'd6,  4'd5,  4'd14, 4'd1,  4'd7}
  };

endpackage

[src/grbd_perm_unit.sv]
// ----------------------------------------------------------------------------
// grbd_perm_unit: descramble datapath
// Picks the permutation row from the address and routes the data bits.
// ----------------------------------------------------------------------------
module grbd_perm_unit import grbd_pkg::*; (
  input  cmd_t              command,
  input  logic [ADDR_W-1:0] byte_address,
  input  logic [DATA_W-1:0] raw_data,
  output logic [DATA_W-1:0] clear_data
);

  logic [ROW_W-1:0]  bg_row;
  logic [ROW_W-1:0]  spr_row;
  logic [BG_W-1:0]   bg_res;
  logic [DATA_W-1:0] spr_res;

  assign bg_row  = {byte_address[BG_ROW_B2], byte_address[BG_ROW_B1],
                    byte_address[BG_ROW_B0]};
  assign spr_row = {byte_address[SPR_ROW_B2], byte_address[SPR_ROW_B1],
                    byte_address[SPR_ROW_B0]};

  // each result bit is a mux of the source bits, one per row
  always_comb begin
    for (int i = 0; i < BG_W; i++) begin
      bg_res[BG_W-1-i] = raw_data[BG_PERM[bg_row][i]];
    end
    for (int i = 0; i < DATA_W; i++) begin
      spr_res[DATA_W-1-i] = raw_data[SPR_PERM[spr_row][i]];
    end
  end

  always_comb begin
    unique case (command)
      CMD_BG:  clear_data = {{(DATA_W-BG_W){1'b0}}, bg_res};
      CMD_SPR: clear_data = spr_res;
      default: clear_data = '0;
    endcase
  end

endmodule

[src/graphics_rom_bit_descrambler_top.sv]
// ----------------------------------------------------------------------------
// graphics_rom_bit_descrambler_top: graphics ROM bit descrambler
// Registers each access, permutes its data bits, registers the result.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | start, busy, in_command, in_byte_address,     | in
//           | in_raw_data                                   |
//   result  | out_valid, out_clear_data                     | out
//
// One transfer per clock: busy stays low, a new access is taken every cycle.
// Path: input register, permute logic, result register.
// out_valid marks each result for exactly one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module graphics_rom_bit_descrambler_top import grbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [ADDR_W-1:0] in_byte_address,
  input  logic [DATA_W-1:0] in_raw_data,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_clear_data
);

  logic              in_valid_r;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] out_data_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start & ~busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r  <= cmd_t'(in_command);
      addr_r <= in_byte_address;
      data_r <= in_raw_data;
    end
    if (in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  grbd_perm_unit u_perm (
    .command      (cmd_r),
    .byte_address (addr_r),
    .raw_data     (data_r),
    .clear_data   (out_data_nxt)
  );

  assign out_valid      = out_valid_r;
  assign out_clear_data = out_data_r;

endmodule

[src/grbd_checker.sv]
// ----------------------------------------------------------------------------
// grbd_checker: port-level checks for the descrambler
// Watches the top-level ports for latency, mode and bit-count properties.
// ----------------------------------------------------------------------------
module grbd_checker import grbd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_command,
  input logic [DATA_W-1:0] in_raw_data,
  input logic              out_valid,
  input logic [DATA_W-1:0] out_clear_data
);

  logic [1:0] rst_hist_r = 2'b00;
  logic       run2;

  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[0], rst_n};
  end

  // run2: both history bits saw rst_n high, so the whole pipe carries real transfers
  assign run2 = rst_hist_r[0] && rst_hist_r[1];

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised although every cycle takes a transfer");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    run2 |-> (out_valid == $past(start && !busy, 2)))
    else $error("result strobe does not follow accepted transfer by two cycles");

  a_bg_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (run2 && out_valid && $past(in_command == CMD_BG, 2)) |->
      (out_clear_data[DATA_W-1:BG_W] == '0))
    else $error("background result has a nonzero upper byte");

  a_bg_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (run2 && out_valid && $past(in_command == CMD_BG, 2)) |->
      ($countones(out_clear_data) == $countones($past(in_raw_data[BG_W-1:0], 2))))
    else $error("background permutation lost or duplicated a bit");

  a_spr_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (run2 && out_valid && $past(in_command == CMD_SPR, 2)) |->
      ($countones(out_clear_data) == $countones($past(in_raw_data, 2))))
    else $error("sprite permutation lost or duplicated a bit");

endmodule

bind graphics_rom_bit_descrambler_top grbd_checker u_grbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .in_raw_data     (in_raw_data),
  .out_valid       (out_valid),
  .out_clear_data  (out_clear_data)
);

[sim/graphics_rom_bit_descrambler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graphics_rom_bit_descrambler_top_tb: self-checking bench for the descrambler
// A directed table of extremes and every permutation row of both commands,
// then random accesses under three sender idle rates. Each accepted access
// queues the typed-in word if known, else one from a local descramble
// function. Each strobed result is compared against the oldest queued word.
// ----------------------------------------------------------------------------
module graphics_rom_bit_descrambler_top_tb;
  import grbd_pkg::*;

  localparam int N_RANDOM   = 1200;
  localparam int N_DIRECTED = 25;
  localparam int CYCLE_CAP  = 50000;
  localparam int DRAIN      = 4;

  // result bit (7-i) takes source bit BG_SRC[row][i]
  localparam logic [2:0] BG_SRC [8][8] = '{
    '{3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd4, 3'd6},
    '{3'd1, 3'd2, 3'd6, 3'd5, 3'd4, 3'd0, 3'd3, 3'd7},
    '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd7, 3'd6, 3'd5, 3'd0, 3'd1, 3'd4, 3'd3, 3'd2},
    '{3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, 3'd7, 3'd6},
    '{3'd5, 3'd3, 3'd7, 3'd0, 3'd4, 3'd6, 3'd2, 3'd1},
    '{3'd2, 3'd7, 3'd0, 3'd6, 3'd5, 3'd3, 3'd1, 3'd4},
    '{3'd3, 3'd4, 3'd7, 3'd6, 3'd2, 3'd0, 3'd5, 3'd1}
  };

  // result bit (15-i) takes source bit SPR_SRC[row][i]
  localparam logic [3:0] SPR_SRC [8][16] = '{
    '{4'd9, 4'd3, 4'd4, 4'd5, 4'd7, 4'd1, 4'd11, 4'd8,
      4'd0, 4'd13, 4'd2, 4'd12, 4'd14, 4'd6, 4'd15, 4'd10},
    '{4'd1, 4'd3, 4'd12, 4'd4, 4'd0, 4'd15, 4'd11, 4'd10,
      4'd8, 4'd5, 4'd14, 4'd6, 4'd13, 4'd2, 4'd7, 4'd9},
    '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
      4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd15, 4'd14, 4'd12, 4'd6, 4'd10, 4'd11, 4'd7, 4'd8,
      4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd13, 4'd1, 4'd0},
    '{4'd1, 4'd6, 4'd2, 4'd5, 4'd15, 4'd7, 4'd11, 4'd9,
      4'd10, 4'd3, 4'd13, 4'd14, 4'd12, 4'd4, 4'd0, 4'd8},
    '{4'd7, 4'd5, 4'd13, 4'd14, 4'd11, 4'd10, 4'd0, 4'd1,
      4'd9, 4'd6, 4'd12, 4'd2, 4'd3, 4'd4, 4'd8, 4'd15},
    '{4'd0, 4'd5, 4'd6, 4'd3, 4'd9, 4'd11, 4'd10, 4'd7,
      4'd1, 4'd13, 4'd2, 4'd14, 4'd4, 4'd12, 4'd8, 4'd15},
    '{4'd9, 4'd12, 4'd4, 4'd2, 4'd15, 4'd0, 4'd11, 4'd8,
      4'd10, 4'd13, 4'd3, 4'd6, 4'd5, 4'd14, 4'd1, 4'd7}
  };

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              known;   // want is typed in, predictor not used
    logic [DATA_W-1:0] want;
  } access_t;

  localparam access_t DIRECTED [N_DIRECTED] = '{
    // extremes, identity rows, ignored upper byte, odd sprite address
    '{CMD_BG,  21'h000000, 16'h0000, 1'b1, 16'h0000},
    '{CMD_BG,  21'h000000, 16'hFFFF, 1'b1, 16'h00FF},
    '{CMD_BG,  21'h1FFFFF, 16'hFFFF, 1'b1, 16'h00FF},
    '{CMD_BG,  21'h000800, 16'h00A5, 1'b1, 16'h00A5},
    '{CMD_BG,  21'h000800, 16'hFF5A, 1'b1, 16'h005A},
    '{CMD_SPR, 21'h000000, 16'h0000, 1'b1, 16'h0000},
    '{CMD_SPR, 21'h1FFFFF, 16'hFFFF, 1'b1, 16'hFFFF},
    '{CMD_SPR, 21'h020000, 16'h1234, 1'b1, 16'h1234},
    '{CMD_SPR, 21'h020001, 16'hBEEF, 1'b1, 16'hBEEF},
    // every background row
    '{CMD_BG,  21'h1BF7FB, 16'hC301, 1'b0, 16'h0000},
    '{CMD_BG,  21'h000004, 16'h0002, 1'b0, 16'h0000},
    '{CMD_BG,  21'h000800, 16'h0004, 1'b0, 16'h0000},
    '{CMD_BG,  21'h000804, 16'h0008, 1'b0, 16'h0000},
    '{CMD_BG,  21'h040000, 16'h0010, 1'b0, 16'h0000},
    '{CMD_BG,  21'h040004, 16'h5520, 1'b0, 16'h0000},
    '{CMD_BG,  21'h040800, 16'h0040, 1'b0, 16'h0000},
    '{CMD_BG,  21'h040804, 16'h0080, 1'b0, 16'h0000},
    // every sprite row
    '{CMD_SPR, 21'h0DFFEF, 16'h0001, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h000010, 16'h0080, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h020000, 16'h8000, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h020010, 16'h0100, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h100000, 16'h00F0, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h100010, 16'h0F00, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h120000, 16'hA5C3, 1'b0, 16'h0000},
    '{CMD_SPR, 21'h120011, 16'h3C5A, 1'b0, 16'h0000}
  };

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic              in_command      = 1'b0;
  logic [ADDR_W-1:0] in_byte_address = '0;
  logic [DATA_W-1:0] in_raw_data     = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_clear_data;

  logic [DATA_W-1:0] pending_clear [$];
  int                idle_pct    = 0;
  int                mismatches  = 0;
  int                n_bg        = 0;
  int                n_spr       = 0;
  int                n_results   = 0;
  int                cycles      = 0;

  graphics_rom_bit_descrambler_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_byte_address (in_byte_address),
    .in_raw_data     (in_raw_data),
    .out_valid       (out_valid),
    .out_clear_data  (out_clear_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] descramble(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                                   logic [DATA_W-1:0] raw);
    logic [2:0]        row;
    logic [DATA_W-1:0] res;
    res = '0;
    if (cmd == CMD_BG) begin
      row = {addr[18], addr[11], addr[2]};
      for (int i = 0; i < 8; i++) res[7-i] = raw[BG_SRC[row][i]];
    end else begin
      row = {addr[20], addr[17], addr[4]};
      for (int i = 0; i < 16; i++) res[15-i] = raw[SPR_SRC[row][i]];
    end
    return res;
  endfunction

  // Called in the step of the previous transfer, so start is never
  // lowered and raised in one step.
  task automatic issue(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                       logic known, logic [DATA_W-1:0] want);
    while ($urandom_range(99) < idle_pct) begin
      start           <= 1'b0;
      in_command      <= 1'($urandom_range(1));
      in_byte_address <= ADDR_W'($urandom);
      in_raw_data     <= DATA_W'($urandom);
      @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_byte_address <= addr;
    in_raw_data     <= data;
    do @(posedge clk); while (busy);
    pending_clear.push_back(known ? want : descramble(cmd, addr, data));
    if (cmd == CMD_BG) n_bg++;
    else n_spr++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_clear.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: clear_data %h", out_clear_data);
        mismatches++;
      end else begin
        if (out_clear_data !== pending_clear[0]) begin
          if (mismatches < 10)
            $display("mismatch: clear_data expected %h, got %h",
                     pending_clear[0], out_clear_data);
          mismatches++;
        end
        void'(pending_clear.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_clear.size());
      $display("FAIL graphics_rom_bit_descrambler_top");
      $finish;
    end
  end

  initial begin
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int                pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      issue(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].data,
            DIRECTED[i].known, DIRECTED[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 0) idle_pct = 36;
      else if (i == N_RANDOM / 3) idle_pct = 69;
      else if (i == 2 * N_RANDOM / 3) idle_pct = 0;
      cmd  = cmd_t'(1'($urandom_range(1)));
      pick = $urandom_range(9);
      addr = ADDR_W'($urandom);
      if (pick == 0) addr = '0;
      else if (pick == 1) addr = '1;
      pick = $urandom_range(9);
      data = DATA_W'($urandom);
      if (pick == 0) data = '0;
      else if (pick == 1) data = '1;
      else if (pick == 2) data = 16'h0001 << $urandom_range(15);
      issue(cmd, addr, data, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_clear.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d background and %0d sprite accesses, %0d results checked",
             n_bg, n_spr, n_results);
    $display("sender idle rates 36, 69 and 0 percent; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_clear.size() == 0) begin
      $display("PASS graphics_rom_bit_descrambler_top");
    end else begin
      $display("FAIL graphics_rom_bit_descrambler_top");
    end
    $finish;
  end

endmodule

[graphics_rom_bit_descrambler_top.f]
src/grbd_pkg.sv
src/grbd_perm_unit.sv
src/graphics_rom_bit_descrambler_top.sv
src/grbd_checker.sv
sim/graphics_rom_bit_descrambler_top_tb.sv
